// ----- design/aml_nsd_pkg.sv -----
package aml_nsd_pkg;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FRESH,
        PH_CARETS,
        PH_PATH,
        PH_COUNT,
        PH_SEG
    } phase_t;

    // Result kind, as carried on m_tuser
    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    // How a byte's group of results ends
    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_DONE,
        TERM_BAD
    } term_t;

    // One classified byte: up to two text characters and an optional terminal result
    typedef struct packed {
        logic [1:0]  n_text;
        logic [7:0]  char0;
        logic [7:0]  char1;
        term_t       term;
        logic        absolute;
        logic [7:0]  hops;
        logic        nul_path;
        logic [15:0] consumed;
    } pkt_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- design/aml_nsd_front.sv -----
module aml_nsd_front #(
    parameter int TEXT_CAP = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              start_req,
    input  logic              final_byte,
    output logic              push,
    output aml_nsd_pkg::pkt_t pkt
);

    localparam int TLEN_W = $clog2(TEXT_CAP);
    localparam logic [TLEN_W:0] CAP_W = (TLEN_W + 1)'(TEXT_CAP);

    localparam logic [7:0] CH_ROOT  = 8'h5C;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] OP_NULL  = 8'h00;
    localparam logic [7:0] OP_DUAL  = 8'h2E;
    localparam logic [7:0] OP_MULTI = 8'h2F;

    function automatic logic lead_ok(input logic [7:0] c);
        return (c == CH_UNDER) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic body_ok(input logic [7:0] c);
        return lead_ok(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic room(input logic [TLEN_W-1:0] len);
        return ({1'b0, len} + (TLEN_W + 1)'(1)) < CAP_W;
    endfunction

    aml_nsd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        seg_tot_reg, seg_tot_next;
    logic [7:0]        seg_idx_reg, seg_idx_next;
    logic [1:0]        ch_idx_reg, ch_idx_next;
    logic [TLEN_W-1:0] tlen_reg, tlen_next;
    logic [7:0]        hops_reg, hops_next;
    logic              root_reg, root_next;
    logic [15:0]       bcnt_reg, bcnt_next;

    aml_nsd_pkg::term_t term;
    logic [1:0] n_text;
    logic [7:0] c0, c1;
    logic       is_null;

    // Next state: classify the byte and update the decoder state
    always_comb begin
        logic active;
        logic do_seg;
        logic bad;
        logic done;
        phase_next   = phase_reg;
        seg_tot_next = seg_tot_reg;
        seg_idx_next = seg_idx_reg;
        ch_idx_next  = ch_idx_reg;
        tlen_next    = tlen_reg;
        hops_next    = hops_reg;
        root_next    = root_reg;
        bcnt_next    = bcnt_reg;
        n_text       = 2'd0;
        c0           = 8'h00;
        c1           = 8'h00;
        is_null      = 1'b0;
        do_seg       = 1'b0;
        bad          = 1'b0;
        done         = 1'b0;
        active       = start_req || (phase_reg != aml_nsd_pkg::PH_IDLE);

        if (start_req) begin
            phase_next   = aml_nsd_pkg::PH_FRESH;
            seg_tot_next = 8'd0;
            seg_idx_next = 8'd0;
            ch_idx_next  = 2'd0;
            tlen_next    = '0;
            hops_next    = 8'd0;
            root_next    = 1'b0;
            bcnt_next    = 16'd0;
        end

        if (active) begin
            if (bcnt_next != 16'hFFFF) begin
                bcnt_next = bcnt_next + 16'd1;
            end

            case (phase_next)
                aml_nsd_pkg::PH_FRESH: begin
                    if (data_byte == CH_ROOT) begin
                        root_next  = 1'b1;
                        phase_next = aml_nsd_pkg::PH_PATH;
                    end else if (data_byte == CH_CARET) begin
                        hops_next  = 8'd1;
                        phase_next = aml_nsd_pkg::PH_CARETS;
                    end else begin
                        do_seg = 1'b1;
                    end
                end
                aml_nsd_pkg::PH_CARETS: begin
                    if (data_byte == CH_CARET) begin
                        if (hops_next != 8'hFF) begin
                            hops_next = hops_next + 8'd1;
                        end
                    end else begin
                        do_seg = 1'b1;
                    end
                end
                aml_nsd_pkg::PH_PATH: begin
                    do_seg = 1'b1;
                end
                aml_nsd_pkg::PH_COUNT: begin
                    if (data_byte == 8'd0) begin
                        bad = 1'b1;
                    end else begin
                        seg_tot_next = data_byte;
                        seg_idx_next = 8'd0;
                        ch_idx_next  = 2'd0;
                        phase_next   = aml_nsd_pkg::PH_SEG;
                    end
                end
                default: begin
                    // segment character; do_seg below covers the work
                end
            endcase

            // Path lead byte: NullName, dual, multi or first char of a single segment
            if (do_seg) begin
                do_seg = 1'b0;
                if (data_byte == OP_NULL) begin
                    is_null = 1'b1;
                    done    = 1'b1;
                end else begin
                    seg_idx_next = 8'd0;
                    ch_idx_next  = 2'd0;
                    if (data_byte == OP_DUAL) begin
                        seg_tot_next = 8'd2;
                        phase_next   = aml_nsd_pkg::PH_SEG;
                    end else if (data_byte == OP_MULTI) begin
                        phase_next = aml_nsd_pkg::PH_COUNT;
                    end else begin
                        seg_tot_next = 8'd1;
                        phase_next   = aml_nsd_pkg::PH_SEG;
                        do_seg       = 1'b1;
                    end
                end
            end else if (phase_reg == aml_nsd_pkg::PH_SEG && !start_req) begin
                do_seg = 1'b1;
            end

            // Segment character, with a dot ahead of every segment but the first
            if (do_seg) begin
                if (ch_idx_next == 2'd0 && seg_idx_next != 8'd0) begin
                    if (!room(tlen_next)) begin
                        bad = 1'b1;
                    end else begin
                        c0        = CH_DOT;
                        n_text    = 2'd1;
                        tlen_next = tlen_next + TLEN_W'(1);
                    end
                end
                if (!bad) begin
                    if ((ch_idx_next == 2'd0) ? !lead_ok(data_byte) : !body_ok(data_byte)) begin
                        bad = 1'b1;
                    end else if (!room(tlen_next)) begin
                        bad = 1'b1;
                    end else begin
                        if (n_text == 2'd0) begin
                            c0 = data_byte;
                        end else begin
                            c1 = data_byte;
                        end
                        n_text      = n_text + 2'd1;
                        tlen_next   = tlen_next + TLEN_W'(1);
                        ch_idx_next = ch_idx_next + 2'd1;
                        if (ch_idx_next == 2'd0) begin
                            seg_idx_next = seg_idx_next + 8'd1;
                            if (seg_idx_next == seg_tot_next) begin
                                done = 1'b1;
                            end
                        end
                    end
                end
            end

            if (!done && final_byte) begin
                bad = 1'b1;
            end
            if (bad || done) begin
                phase_next = aml_nsd_pkg::PH_IDLE;
            end
        end

        if (bad) begin
            term   = aml_nsd_pkg::TERM_BAD;
            n_text = 2'd0;
        end else if (done) begin
            term = aml_nsd_pkg::TERM_DONE;
        end else begin
            term = aml_nsd_pkg::TERM_NONE;
        end
    end

    // Outputs: build the queue entry for this byte
    always_comb begin
        pkt.n_text    = n_text;
        pkt.char0     = c0;
        pkt.char1     = c1;
        pkt.term      = term;
        pkt.absolute  = (term == aml_nsd_pkg::TERM_DONE) ? root_next : 1'b0;
        pkt.hops      = (term == aml_nsd_pkg::TERM_DONE) ? hops_next : 8'd0;
        pkt.nul_path  = (term == aml_nsd_pkg::TERM_DONE) && is_null;
        pkt.consumed  = (term != aml_nsd_pkg::TERM_NONE) ? bcnt_next : 16'd0;
        push          = take && ((n_text != 2'd0) || (term != aml_nsd_pkg::TERM_NONE));
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= aml_nsd_pkg::PH_IDLE;
            seg_tot_reg <= 8'd0;
            seg_idx_reg <= 8'd0;
            ch_idx_reg  <= 2'd0;
            tlen_reg    <= '0;
            hops_reg    <= 8'd0;
            root_reg    <= 1'b0;
            bcnt_reg    <= 16'd0;
        end else if (take) begin
            phase_reg   <= phase_next;
            seg_tot_reg <= seg_tot_next;
            seg_idx_reg <= seg_idx_next;
            ch_idx_reg  <= ch_idx_next;
            tlen_reg    <= tlen_next;
            hops_reg    <= hops_next;
            root_reg    <= root_next;
            bcnt_reg    <= bcnt_next;
        end
    end

endmodule

// ----- design/aml_nsd_fifo.sv -----
module aml_nsd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  aml_nsd_pkg::pkt_t push_pkt,
    output logic              full,
    output logic              head_valid,
    output aml_nsd_pkg::pkt_t head_pkt,
    input  logic              pop
);

    localparam int AW = aml_nsd_pkg::FIFO_AW;
    localparam int CW = aml_nsd_pkg::FIFO_CW;
    localparam logic [CW-1:0] DEPTH_C = CW'(aml_nsd_pkg::FIFO_DEPTH);

    aml_nsd_pkg::pkt_t mem_reg [aml_nsd_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_pkt   = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue fill beyond depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("transfer into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

// ----- design/aml_nsd_back.sv -----
module aml_nsd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  aml_nsd_pkg::pkt_t head_pkt,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic        slot_reg, slot_next;
    logic        valid_reg, valid_next;
    aml_nsd_pkg::kind_t kind_reg, kind_next;
    logic [7:0]  char_reg, char_next;
    logic        abs_reg, abs_next;
    logic [7:0]  hops_reg, hops_next;
    logic        null_reg, null_next;
    logic [15:0] cons_reg, cons_next;
    logic        last_reg, last_next;

    // Pick the result at the current slot of the head entry
    always_comb begin
        logic       load;
        logic       is_text;
        logic       is_final;
        logic [1:0] total;
        load     = !valid_reg || m_tready;
        total    = head_pkt.n_text + ((head_pkt.term != aml_nsd_pkg::TERM_NONE) ? 2'd1 : 2'd0);
        is_text  = ({1'b0, slot_reg} < head_pkt.n_text);
        is_final = ({1'b0, slot_reg} == total - 2'd1);

        slot_next  = slot_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        char_next  = char_reg;
        abs_next   = abs_reg;
        hops_next  = hops_reg;
        null_next  = null_reg;
        cons_next  = cons_reg;
        last_next  = last_reg;
        pop        = 1'b0;

        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                pop       = is_final;
                slot_next = is_final ? 1'b0 : 1'b1;
                if (is_text) begin
                    kind_next = aml_nsd_pkg::KIND_TEXT;
                    char_next = slot_reg ? head_pkt.char1 : head_pkt.char0;
                    abs_next  = 1'b0;
                    hops_next = 8'd0;
                    null_next = 1'b0;
                    cons_next = 16'd0;
                    last_next = is_final;
                end else begin
                    kind_next = (head_pkt.term == aml_nsd_pkg::TERM_DONE) ?
                                aml_nsd_pkg::KIND_DONE : aml_nsd_pkg::KIND_BAD;
                    char_next = 8'h00;
                    abs_next  = head_pkt.absolute;
                    hops_next = head_pkt.hops;
                    null_next = head_pkt.nul_path;
                    cons_next = head_pkt.consumed;
                    last_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        abs_reg  <= abs_next;
        hops_reg <= hops_next;
        null_reg <= null_next;
        cons_reg <= cons_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, cons_reg, null_reg, hops_reg, abs_reg, char_reg};

    a_term_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg != aml_nsd_pkg::KIND_TEXT) |-> last_reg)
        else $error("terminal result without last");

endmodule

// ----- design/aml_name_string_decoder.sv -----
// Channel | Signals                               | Content
// s_      | s_tvalid s_tready s_tdata s_tuser s_tlast | one AML byte, start flag, final flag
// m_      | m_tvalid m_tready m_tdata m_tuser m_tlast | one result: kind, char or summary
//
// One byte is taken every cycle while the four-entry queue has room.
// The back end sends one result per cycle while m_tready is high, so a byte giving two results
// (a dot and a character, or a last character and the completion) holds its queue entry for both.
// A result passes through the queue and then the output register before it leaves.
// aresetn is synchronous, active low, and clears the decoder, queue and output valid.
// A stalled m_ side fills the queue, then drops s_tready.
module aml_name_string_decoder #(
    parameter int TEXT_CAP = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_req
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] text_char, [8] absolute, [16:9] parent_hops, [17] null path flag,
    // [33:18] consumed, [39:34] zero
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);

    logic              q_full;
    logic              take;
    logic              push;
    aml_nsd_pkg::pkt_t push_pkt;
    logic              head_valid;
    aml_nsd_pkg::pkt_t head_pkt;
    logic              pop;

    assign s_tready = !q_full;
    assign take     = s_tvalid && !q_full;

    aml_nsd_front #(
        .TEXT_CAP (TEXT_CAP)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .data_byte  (s_tdata),
        .start_req  (s_tuser),
        .final_byte (s_tlast),
        .push       (push),
        .pkt        (push_pkt)
    );

    aml_nsd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_pkt   (push_pkt),
        .full       (q_full),
        .head_valid (head_valid),
        .head_pkt   (head_pkt),
        .pop        (pop)
    );

    aml_nsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_pkt   (head_pkt),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- sim/testbench.sv -----
module testbench;

    localparam int TEXT_CAP    = 64;
    localparam int QUIET_LIMIT = 3000;

    // AML lead bytes and name characters
    localparam logic [7:0] NUL_PATH     = 8'h00;
    localparam logic [7:0] DUAL_PREFIX  = 8'h2E;
    localparam logic [7:0] MULTI_PREFIX = 8'h2F;
    localparam logic [7:0] ROOT_CHAR    = 8'h5C;
    localparam logic [7:0] PARENT_CHAR  = 8'h5E;
    localparam logic [7:0] UNDERSCORE   = 8'h5F;
    localparam logic [7:0] DOT_CHAR     = 8'h2E;

    // One result as seen on the m_ channel
    typedef struct packed {
        aml_nsd_pkg::kind_t kind;
        logic [7:0]  ch;
        logic        absl;
        logic [7:0]  hops;
        logic        nul;
        logic [15:0] used;
        logic        lst;
    } result_t;

    // One directed byte; pinned rows carry their single result typed in
    typedef struct packed {
        logic [7:0] b;
        logic       st;
        logic       fin;
        logic       pinned;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_PIN     = '0;
    localparam result_t NULL_ONLY  =
        '{aml_nsd_pkg::KIND_DONE, 8'h00, 1'b0, 8'd0, 1'b1, 16'd1, 1'b1};
    localparam result_t ROOT_NULL  =
        '{aml_nsd_pkg::KIND_DONE, 8'h00, 1'b1, 8'd0, 1'b1, 16'd2, 1'b1};
    localparam result_t BAD_FIRST  =
        '{aml_nsd_pkg::KIND_BAD, 8'h00, 1'b0, 8'd0, 1'b0, 16'd1, 1'b1};
    localparam result_t BAD_SECOND =
        '{aml_nsd_pkg::KIND_BAD, 8'h00, 1'b0, 8'd0, 1'b0, 16'd2, 1'b1};

    localparam int N_DIRECTED = 24;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{8'h41,        1'b0, 1'b0, 1'b0, NO_PIN},      // stray byte while idle
        '{NUL_PATH,     1'b1, 1'b1, 1'b1, NULL_ONLY},   // bare NullName
        '{ROOT_CHAR,    1'b1, 1'b0, 1'b0, NO_PIN},
        '{NUL_PATH,     1'b0, 1'b0, 1'b1, ROOT_NULL},   // root then NullName
        '{PARENT_CHAR,  1'b1, 1'b0, 1'b0, NO_PIN},
        '{PARENT_CHAR,  1'b0, 1'b0, 1'b0, NO_PIN},
        '{UNDERSCORE,   1'b0, 1'b0, 1'b0, NO_PIN},      // single segment "_AZ9"
        '{8'h41,        1'b0, 1'b0, 1'b0, NO_PIN},
        '{8'h5A,        1'b0, 1'b0, 1'b0, NO_PIN},
        '{8'h39,        1'b0, 1'b1, 1'b0, NO_PIN},      // final byte that completes
        '{MULTI_PREFIX, 1'b1, 1'b0, 1'b0, NO_PIN},
        '{8'h02,        1'b0, 1'b0, 1'b0, NO_PIN},
        '{8'h5A,        1'b0, 1'b0, 1'b0, NO_PIN},
        '{8'h30,        1'b0, 1'b0, 1'b0, NO_PIN},
        '{UNDERSCORE,   1'b0, 1'b0, 1'b0, NO_PIN},
        '{UNDERSCORE,   1'b0, 1'b0, 1'b0, NO_PIN},
        '{8'h41,        1'b0, 1'b0, 1'b0, NO_PIN},      // dot plus lead char
        '{MULTI_PREFIX, 1'b1, 1'b0, 1'b0, NO_PIN},      // restart drops the open name
        '{NUL_PATH,     1'b0, 1'b0, 1'b1, BAD_SECOND},  // zero segment count
        '{8'h30,        1'b1, 1'b0, 1'b1, BAD_FIRST},   // digit as lead char
        '{8'hFF,        1'b1, 1'b1, 1'b1, BAD_FIRST},
        '{ROOT_CHAR,    1'b1, 1'b0, 1'b0, NO_PIN},
        '{PARENT_CHAR,  1'b0, 1'b0, 1'b1, BAD_SECOND},  // caret after root
        '{DUAL_PREFIX,  1'b1, 1'b1, 1'b1, BAD_FIRST}    // out of bytes
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Travels with the byte on offer so the monitor knows about pinned rows
    logic    drive_pinned = 1'b0;
    result_t drive_want   = '0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int bytes_sent   = 0;
    int errors       = 0;
    int quiet_cycles = 0;

    // Decoder mirror
    aml_nsd_pkg::phase_t dec_phase;
    logic [7:0] segs_total;
    logic [7:0] seg_no;
    logic [1:0] char_no;
    int         text_len;
    logic [7:0] caret_hops;
    logic       rooted;
    logic [15:0] bytes_used;
    logic       saw_null;
    logic [7:0] new_chars [2];
    int         n_new;

    result_t byte_results    [$];
    result_t pending_results [$];

    aml_name_string_decoder #(
        .TEXT_CAP (TEXT_CAP)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic bit name_lead_ok(input logic [7:0] c);
        return c == UNDERSCORE || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit name_body_ok(input logic [7:0] c);
        return name_lead_ok(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic void clear_decoder();
        dec_phase  = aml_nsd_pkg::PH_IDLE;
        segs_total = '0;
        seg_no     = '0;
        char_no    = '0;
        text_len   = 0;
        caret_hops = '0;
        rooted     = 1'b0;
        bytes_used = '0;
    endfunction

    // One NameSeg byte: dot first when a new segment opens, then the char
    function automatic aml_nsd_pkg::term_t seg_char(input logic [7:0] b);
        if (char_no == 2'd0 && seg_no != 8'd0) begin
            if (text_len + 1 >= TEXT_CAP)
                return aml_nsd_pkg::TERM_BAD;
            new_chars[n_new] = DOT_CHAR;
            n_new++;
            text_len++;
        end
        if (char_no == 2'd0 ? !name_lead_ok(b) : !name_body_ok(b))
            return aml_nsd_pkg::TERM_BAD;
        if (text_len + 1 >= TEXT_CAP)
            return aml_nsd_pkg::TERM_BAD;
        new_chars[n_new] = b;
        n_new++;
        text_len++;
        char_no = char_no + 2'd1;
        if (char_no == 2'd0) begin
            seg_no++;
            if (seg_no == segs_total)
                return aml_nsd_pkg::TERM_DONE;
        end
        return aml_nsd_pkg::TERM_NONE;
    endfunction

    // First byte after the prefix picks the path form
    function automatic aml_nsd_pkg::term_t path_lead(input logic [7:0] b);
        if (b == NUL_PATH) begin
            saw_null = 1'b1;
            return aml_nsd_pkg::TERM_DONE;
        end
        seg_no  = '0;
        char_no = '0;
        if (b == DUAL_PREFIX) begin
            segs_total = 8'd2;
            dec_phase  = aml_nsd_pkg::PH_SEG;
            return aml_nsd_pkg::TERM_NONE;
        end
        if (b == MULTI_PREFIX) begin
            dec_phase = aml_nsd_pkg::PH_COUNT;
            return aml_nsd_pkg::TERM_NONE;
        end
        segs_total = 8'd1;
        dec_phase  = aml_nsd_pkg::PH_SEG;
        return seg_char(b);
    endfunction

    // Works out the results of one accepted byte into byte_results
    function automatic void decode_byte(input logic [7:0] b, input logic st, input logic fin);
        aml_nsd_pkg::term_t t;
        result_t r;
        byte_results = {};
        t        = aml_nsd_pkg::TERM_NONE;
        n_new    = 0;
        saw_null = 1'b0;
        if (st) begin
            clear_decoder();
            dec_phase = aml_nsd_pkg::PH_FRESH;
        end else if (dec_phase == aml_nsd_pkg::PH_IDLE) begin
            return;
        end
        if (bytes_used != 16'hFFFF)
            bytes_used++;

        case (dec_phase)
            aml_nsd_pkg::PH_FRESH: begin
                if (b == ROOT_CHAR) begin
                    rooted    = 1'b1;
                    dec_phase = aml_nsd_pkg::PH_PATH;
                end else if (b == PARENT_CHAR) begin
                    caret_hops = 8'd1;
                    dec_phase  = aml_nsd_pkg::PH_CARETS;
                end else begin
                    t = path_lead(b);
                end
            end
            aml_nsd_pkg::PH_CARETS: begin
                if (b == PARENT_CHAR) begin
                    if (caret_hops != 8'hFF)
                        caret_hops++;
                end else begin
                    t = path_lead(b);
                end
            end
            aml_nsd_pkg::PH_PATH: t = path_lead(b);
            aml_nsd_pkg::PH_COUNT: begin
                if (b == 8'd0) begin
                    t = aml_nsd_pkg::TERM_BAD;
                end else begin
                    segs_total = b;
                    seg_no     = '0;
                    char_no    = '0;
                    dec_phase  = aml_nsd_pkg::PH_SEG;
                end
            end
            default: t = seg_char(b);
        endcase

        if (t == aml_nsd_pkg::TERM_NONE && fin)
            t = aml_nsd_pkg::TERM_BAD;

        // malformed replaces anything else this byte would have given
        if (t == aml_nsd_pkg::TERM_BAD) begin
            r      = '0;
            r.kind = aml_nsd_pkg::KIND_BAD;
            r.used = bytes_used;
            r.lst  = 1'b1;
            byte_results.push_back(r);
            dec_phase = aml_nsd_pkg::PH_IDLE;
            return;
        end
        for (int i = 0; i < n_new; i++) begin
            r      = '0;
            r.kind = aml_nsd_pkg::KIND_TEXT;
            r.ch   = new_chars[i];
            r.lst  = (i == n_new - 1) && t != aml_nsd_pkg::TERM_DONE;
            byte_results.push_back(r);
        end
        if (t == aml_nsd_pkg::TERM_DONE) begin
            r      = '0;
            r.kind = aml_nsd_pkg::KIND_DONE;
            r.absl = rooted;
            r.hops = caret_hops;
            r.nul  = saw_null;
            r.used = bytes_used;
            r.lst  = 1'b1;
            byte_results.push_back(r);
            dec_phase = aml_nsd_pkg::PH_IDLE;
        end
    endfunction

    function automatic void check_field(input string what, input longint want,
                                        input longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    // Offer one byte, idling beforehand at random; returns once it is transferred
    task automatic push_byte(input logic [7:0] b, input logic st, input logic fin,
                             input logic pinned, input result_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid     <= 1'b1;
        s_tdata      <= b;
        s_tuser      <= st;
        s_tlast      <= fin;
        drive_pinned <= pinned;
        drive_want   <= want;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_lead();
        int r;
        r = $urandom_range(26);
        return (r == 26) ? UNDERSCORE : 8'("A" + r);
    endfunction

    function automatic logic [7:0] rand_body();
        int r;
        r = $urandom_range(36);
        if (r < 26)
            return 8'("A" + r);
        if (r < 36)
            return 8'("0" + r - 26);
        return UNDERSCORE;
    endfunction

    // A mostly well-formed NameString with random content, sometimes broken
    task automatic send_random_name();
        logic [7:0] name_bytes [$];
        int nseg, pick, fin_at;
        bit fin_end;
        pick = $urandom_range(19);
        if (pick < 4)
            name_bytes.push_back(ROOT_CHAR);
        else if (pick < 9)
            repeat ($urandom_range(1, 4)) name_bytes.push_back(PARENT_CHAR);
        else if (pick == 9 && $urandom_range(9) == 0)
            repeat ($urandom_range(250, 260)) name_bytes.push_back(PARENT_CHAR);

        pick = $urandom_range(19);
        nseg = 0;
        if (pick == 0) begin
            name_bytes.push_back(NUL_PATH);
        end else if (pick < 8) begin
            nseg = 1;
        end else if (pick < 13) begin
            name_bytes.push_back(DUAL_PREFIX);
            nseg = 2;
        end else begin
            name_bytes.push_back(MULTI_PREFIX);
            case ($urandom_range(9))
                0:       nseg = 0;
                1:       nseg = 255;
                2:       nseg = $urandom_range(13, 254);
                default: nseg = $urandom_range(1, 12);
            endcase
            name_bytes.push_back(nseg[7:0]);
            // the text cap is hit before this
            if (nseg > 14)
                nseg = 14;
        end
        for (int i = 0; i < nseg; i++) begin
            name_bytes.push_back(rand_lead());
            repeat (3) name_bytes.push_back(rand_body());
        end

        // breakage: a stray byte, a cut-off tail, an early final flag
        if ($urandom_range(11) == 0)
            name_bytes[$urandom_range(name_bytes.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(19) == 0 && name_bytes.size() > 1)
            name_bytes = name_bytes[0:$urandom_range(name_bytes.size() - 2)];
        fin_at  = ($urandom_range(29) == 0) ? $urandom_range(name_bytes.size() - 1) : -1;
        fin_end = 1'($urandom_range(1));

        for (int i = 0; i < name_bytes.size(); i++)
            push_byte(name_bytes[i], i == 0,
                      i == fin_at || (fin_end && i == name_bytes.size() - 1), 1'b0, NO_PIN);
    endtask

    // Monitor: predict on each input transfer, check each result transfer
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            quiet_cycles = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser, s_tlast);
                if (drive_pinned)
                    pending_results.push_back(drive_want);
                else
                    foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, kind %0d data %0h last %0b",
                             $time, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("text_char", want.ch, m_tdata[7:0]);
                    check_field("absolute", want.absl, m_tdata[8]);
                    check_field("parent_hops", want.hops, m_tdata[16:9]);
                    check_field("null path", want.nul, m_tdata[17]);
                    check_field("consumed", want.used, m_tdata[33:18]);
                    check_field("pad bits", 0, m_tdata[39:34]);
                    check_field("last", want.lst, m_tlast);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Result side: random stalls, plus one long hold-off to back up the queue
    initial begin : sink
        int sink_cycles;
        sink_cycles = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            sink_cycles++;
            if (sink_cycles == 400) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog on stalled traffic
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        int target;
        clear_decoder();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        src_idle_pct = 23;
        snk_idle_pct <= 58;
        @(posedge aclk);

        foreach (DIRECTED[i])
            push_byte(DIRECTED[i].b, DIRECTED[i].st, DIRECTED[i].fin,
                      DIRECTED[i].pinned, DIRECTED[i].want);

        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: begin
                    src_idle_pct = 23;
                    snk_idle_pct <= 58;
                end
                1: begin
                    src_idle_pct = 58;
                    snk_idle_pct <= 23;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct <= 0;
                end
            endcase
            target = bytes_sent + 360;
            while (bytes_sent < target) begin
                if ($urandom_range(6) == 0)
                    repeat ($urandom_range(1, 3))
                        push_byte(8'($urandom), $urandom_range(3) == 0,
                                  $urandom_range(3) == 0, 1'b0, NO_PIN);
                else
                    send_random_name();
            end
        end

        // one long caret run: the hop count saturates
        push_byte(PARENT_CHAR, 1'b1, 1'b0, 1'b0, NO_PIN);
        repeat (259) push_byte(PARENT_CHAR, 1'b0, 1'b0, 1'b0, NO_PIN);
        for (int i = 0; i < 4; i++)
            push_byte(8'("A" + i), 1'b0, i == 3, 1'b0, NO_PIN);
        s_tvalid <= 1'b0;

        // drain, then a short tail for stray results
        @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
